// ----- sv/m4ae_pkg.sv -----
// m4ae_pkg: shared types and constants for the 4x4 fixed-point matrix engine.
// No dependencies; imported by matrix4_arithmetic_engine_top.
`default_nettype none

package m4ae_pkg;

    // Fraction bits of the signed fixed-point format (default).
    localparam int FRAC_BITS_DEF = 16;

    // Element and index widths.
    localparam int ELEM_W = 32;
    localparam int IDX_W  = 2;
    localparam int ADDR_W = 2 * IDX_W;

    // Operation codes carried in the mode field.
    typedef enum logic [2:0] {
        MODE_LOAD_A    = 3'd0,
        MODE_LOAD_B    = 3'd1,
        MODE_MUL       = 3'd2,
        MODE_ADD       = 3'd3,
        MODE_SUB       = 3'd4,
        MODE_SCALE     = 3'd5,
        MODE_TRANSPOSE = 3'd6,
        MODE_NOP       = 3'd7
    } mode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_ACC,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ----- sv/matrix4_arithmetic_engine_top.sv -----
// matrix4_arithmetic_engine_top: 4x4 signed fixed-point matrix engine (A*B, A+B, A-B,
// scale, transpose) built around two small synchronous memories. Depends on m4ae_pkg.
`default_nettype none

// Channel   Direction  Handshake             Payload
// -------   ---------  --------------------  ------------------------------------
// in        sink       in_valid / in_stall   mode, row, col, value
// out       source     out_valid / out_stall row_res, col_res, value_res, last
//
// Steps: a load is written in idle. Add, subtract, scale and transpose pass each of
// the 16 elements through read, multiply, combine and transfer states. A*B passes each
// product term through read, multiply and accumulate states on the single 32x32
// multiplier, then takes one transfer state per element.
// Reset clears the sequencer and the bank select only; the matrix memories hold
// whatever they held. An out stall holds the sequencer in its transfer state.

module matrix4_arithmetic_engine_top #(
    parameter int FRAC_BITS = m4ae_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           mode,
    input  logic [m4ae_pkg::IDX_W-1:0]           row,
    input  logic [m4ae_pkg::IDX_W-1:0]           col,
    input  logic signed [m4ae_pkg::ELEM_W-1:0]   value,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [m4ae_pkg::IDX_W-1:0]           row_res,
    output logic [m4ae_pkg::IDX_W-1:0]           col_res,
    output logic signed [m4ae_pkg::ELEM_W-1:0]   value_res,
    output logic                                 last
);

    import m4ae_pkg::*;

    // A floored product is at most 2^(62-FRAC_BITS) in magnitude; four of them
    // plus a sign need this many bits.
    localparam int ACC_W  = 2 * ELEM_W + 2 - FRAC_BITS;
    localparam int PROD_W = 2 * ELEM_W;

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-ELEM_W+1){1'b1}}, {(ELEM_W-1){1'b0}}};
    localparam logic [ADDR_W-1:0] LAST_ELEM = {ADDR_W{1'b1}};
    localparam logic [IDX_W-1:0]  LAST_K    = {IDX_W{1'b1}};

    // Working matrix A lives in two banks: an operation reads the current bank
    // and writes its result into the other one, then flips the bank select.
    logic [ELEM_W-1:0] mem_a [2**(ADDR_W+1)];
    logic [ELEM_W-1:0] mem_b [2**ADDR_W];

    state_t                    state_reg, state_next;
    mode_t                     op_reg;
    logic signed [ELEM_W-1:0]  scale_reg;
    logic [ADDR_W-1:0]         elem_reg;
    logic [IDX_W-1:0]          k_reg;
    logic                      bank_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ELEM_W-1:0]  rd_a_reg, rd_b_reg;
    logic [IDX_W-1:0]          row_res_reg, col_res_reg;
    logic signed [ELEM_W-1:0]  value_res_reg;
    logic                      last_reg;

    logic                      in_xfer, out_xfer;
    mode_t                     in_mode;
    logic [IDX_W-1:0]          ei, ej;
    logic [ADDR_W-1:0]         a_idx, b_idx;
    logic [ADDR_W:0]           rd_a_addr, wr_a_addr;
    logic                      wr_a_en, wr_b_en;
    logic [ELEM_W-1:0]         wr_a_data;
    logic                      elem_done;
    logic                      is_mul_op;
    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [ACC_W-1:0]   prod_fl;
    logic signed [ELEM_W:0]    sum_ext;
    logic signed [ACC_W-1:0]   sat_in;
    logic signed [ELEM_W-1:0]  sat_out;
    logic signed [ELEM_W-1:0]  mul_b;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign in_mode  = mode_t'(mode);

    // ---------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && in_mode != MODE_LOAD_A && in_mode != MODE_LOAD_B
                    && in_mode != MODE_NOP)
                    state_next = ST_READ;
            end
            ST_READ: state_next = ST_CALC;
            ST_CALC: state_next = ST_ACC;
            ST_ACC:  state_next = elem_done ? ST_OUT : ST_READ;
            ST_OUT:
            begin
                if (out_xfer)
                    state_next = (elem_reg == LAST_ELEM) ? ST_IDLE : ST_READ;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // FSM outputs: handshake control
    // ---------------------------------------------------------------
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_OUT);
    end

    // ---------------------------------------------------------------
    // Address generation: A*B walks row i of A against column j of B,
    // transpose reads the mirrored element, the rest read element e.
    // ---------------------------------------------------------------
    assign ei = elem_reg[ADDR_W-1:IDX_W];
    assign ej = elem_reg[IDX_W-1:0];
    assign is_mul_op = (op_reg == MODE_MUL);

    always_comb
    begin
        unique case (op_reg)
            MODE_MUL:
            begin
                a_idx = {ei, k_reg};
                b_idx = {k_reg, ej};
            end
            MODE_TRANSPOSE:
            begin
                a_idx = {ej, ei};
                b_idx = elem_reg;
            end
            default:
            begin
                a_idx = elem_reg;
                b_idx = elem_reg;
            end
        endcase
    end

    assign rd_a_addr = {bank_reg, a_idx};
    assign elem_done = !is_mul_op || (k_reg == LAST_K);

    // ---------------------------------------------------------------
    // Arithmetic: floor shift, accumulate, saturate
    // ---------------------------------------------------------------
    assign mul_b   = (op_reg == MODE_SCALE) ? scale_reg : rd_b_reg;
    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign prod_fl = prod_sh[ACC_W-1:0];

    always_comb
    begin
        acc_next = ((k_reg == '0) ? '0 : acc_reg) + prod_fl;
        sum_ext  = '0;
        unique case (op_reg)
            MODE_MUL:   sat_in = acc_next;
            MODE_SCALE: sat_in = prod_fl;
            MODE_ADD:
            begin
                sum_ext = {rd_a_reg[ELEM_W-1], rd_a_reg} + {rd_b_reg[ELEM_W-1], rd_b_reg};
                sat_in  = {{(ACC_W-ELEM_W-1){sum_ext[ELEM_W]}}, sum_ext};
            end
            MODE_SUB:
            begin
                sum_ext = {rd_a_reg[ELEM_W-1], rd_a_reg} - {rd_b_reg[ELEM_W-1], rd_b_reg};
                sat_in  = {{(ACC_W-ELEM_W-1){sum_ext[ELEM_W]}}, sum_ext};
            end
            default:    sat_in = {{(ACC_W-ELEM_W){rd_a_reg[ELEM_W-1]}}, rd_a_reg};
        endcase

        priority if (sat_in > SAT_MAX)
            sat_out = SAT_MAX[ELEM_W-1:0];
        else if (sat_in < SAT_MIN)
            sat_out = SAT_MIN[ELEM_W-1:0];
        else
            sat_out = sat_in[ELEM_W-1:0];
    end

    // ---------------------------------------------------------------
    // Memory write ports. A loads go to the current bank of A, B loads to mem_b;
    // results go to A's other bank, so no read in flight ever sees a new value.
    // ---------------------------------------------------------------
    always_comb
    begin
        wr_b_en   = in_xfer && (in_mode == MODE_LOAD_B);
        wr_a_en   = (in_xfer && (in_mode == MODE_LOAD_A))
                    || (state_reg == ST_ACC && elem_done);
        wr_a_addr = (state_reg == ST_IDLE) ? {bank_reg, row, col} : {!bank_reg, elem_reg};
        wr_a_data = (state_reg == ST_IDLE) ? value : sat_out;
    end

    always_ff @(posedge clk)
    begin
        if (wr_a_en)
            mem_a[wr_a_addr] <= wr_a_data;
        rd_a_reg <= mem_a[rd_a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b_en)
            mem_b[{row, col}] <= value;
        rd_b_reg <= mem_b[b_idx];
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= MODE_NOP;
            elem_reg  <= '0;
            k_reg     <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && in_xfer)
            begin
                op_reg   <= in_mode;
                elem_reg <= '0;
                k_reg    <= '0;
            end
            // Advance the term index, or the element once its transfer completes.
            if (state_reg == ST_ACC && !elem_done)
                k_reg <= k_reg + 1'b1;
            if (state_reg == ST_OUT && out_xfer)
            begin
                k_reg    <= '0;
                elem_reg <= elem_reg + 1'b1;
                if (elem_reg == LAST_ELEM)
                    bank_reg <= !bank_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers (no reset)
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_xfer)
            scale_reg <= value;
        if (state_reg == ST_CALC)
            prod_reg <= rd_a_reg * mul_b;
        if (state_reg == ST_ACC)
        begin
            acc_reg <= acc_next;
            if (elem_done)
            begin
                row_res_reg   <= ei;
                col_res_reg   <= ej;
                value_res_reg <= sat_out;
                last_reg      <= (elem_reg == LAST_ELEM);
            end
        end
    end

    assign row_res   = row_res_reg;
    assign col_res   = col_res_reg;
    assign value_res = value_res_reg;
    assign last      = last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_last_at_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> row_res == LAST_K && col_res == LAST_K)
        else $error("last flag away from the final element");

    a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result is pending");

    a_op_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode >= MODE_MUL && mode <= MODE_TRANSPOSE |=> in_stall)
        else $error("operation accepted but sequencer did not start");

    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !in_stall && !out_valid)
        else $error("sequencer did not return to idle after the final transfer");

endmodule

`default_nettype wire

// ----- verif/matrix4_arithmetic_engine_checker.sv -----
// Transfer monitor and result predictor for the 4x4 fixed-point matrix engine.
// Depends on m4ae_pkg; instantiated beside the block by matrix4_arithmetic_engine_top_test.
`default_nettype none

module matrix4_arithmetic_engine_checker #(
    parameter int FRAC_BITS = m4ae_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [2:0]                           mode,
    input  logic [m4ae_pkg::IDX_W-1:0]           row,
    input  logic [m4ae_pkg::IDX_W-1:0]           col,
    input  logic signed [m4ae_pkg::ELEM_W-1:0]   value,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [m4ae_pkg::IDX_W-1:0]           row_res,
    input  logic [m4ae_pkg::IDX_W-1:0]           col_res,
    input  logic signed [m4ae_pkg::ELEM_W-1:0]   value_res,
    input  logic                                 last,
    output int                                   errors,
    output int                                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import m4ae_pkg::*;

    localparam longint ELEM_MAX = 64'sd2147483647;
    localparam longint ELEM_MIN = -64'sd2147483648;

    typedef struct {
        logic [IDX_W-1:0]         rix;
        logic [IDX_W-1:0]         cix;
        logic signed [ELEM_W-1:0] val;
        logic                     fin;
    } elem_t;

    logic signed [ELEM_W-1:0] work_a    [16];
    logic signed [ELEM_W-1:0] operand_b [16];
    elem_t                    result_elems_due [$];

    initial
    begin
        errors  = 0;
        pending = 0;
        for (int i = 0; i < 16; i++)
        begin
            work_a[i]    = '0;
            operand_b[i] = '0;
        end
    end

    // Exact product, floored to the fixed-point grid.
    function automatic longint mul_q(input logic signed [ELEM_W-1:0] x,
                                     input logic signed [ELEM_W-1:0] y);
        longint prod;
        prod = longint'(x) * longint'(y);
        return prod >>> FRAC_BITS;
    endfunction

    function automatic logic signed [ELEM_W-1:0] clamp32(input longint v);
        if (v > ELEM_MAX)
            return 32'sh7FFFFFFF;
        if (v < ELEM_MIN)
            return 32'sh80000000;
        return v[ELEM_W-1:0];
    endfunction

    // Apply one accepted item to the shadow matrices; queue the 16 elements of an operation.
    task automatic predict_engine(input mode_t op, input logic [IDX_W-1:0] r,
                                  input logic [IDX_W-1:0] c,
                                  input logic signed [ELEM_W-1:0] v);
        logic signed [ELEM_W-1:0] res [16];
        longint                   acc;
        logic                     emits;
        elem_t                    e;
        emits = 1'b1;
        case (op)
            MODE_LOAD_A:
            begin
                work_a[{r, c}] = v;
                emits = 1'b0;
            end
            MODE_LOAD_B:
            begin
                operand_b[{r, c}] = v;
                emits = 1'b0;
            end
            MODE_MUL:
                for (int i = 0; i < 4; i++)
                    for (int j = 0; j < 4; j++)
                    begin
                        acc = 0;
                        for (int k = 0; k < 4; k++)
                            acc += mul_q(work_a[i*4+k], operand_b[k*4+j]);
                        res[i*4+j] = clamp32(acc);
                    end
            MODE_ADD:
                for (int i = 0; i < 16; i++)
                    res[i] = clamp32(longint'(work_a[i]) + longint'(operand_b[i]));
            MODE_SUB:
                for (int i = 0; i < 16; i++)
                    res[i] = clamp32(longint'(work_a[i]) - longint'(operand_b[i]));
            MODE_SCALE:
                for (int i = 0; i < 16; i++)
                    res[i] = clamp32(mul_q(work_a[i], v));
            MODE_TRANSPOSE:
                for (int i = 0; i < 4; i++)
                    for (int j = 0; j < 4; j++)
                        res[i*4+j] = work_a[j*4+i];
            default:
                emits = 1'b0;
        endcase
        if (emits)
        begin
            for (int i = 0; i < 16; i++)
            begin
                work_a[i] = res[i];
                e.rix = i[3:2];
                e.cix = i[1:0];
                e.val = res[i];
                e.fin = (i == 15);
                result_elems_due.push_back(e);
            end
        end
    endtask

    // Print one line and count.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        elem_t exp_e;
        if (rst_n)
        begin
            // Drain before fill: a result leaving now belongs to an earlier item.
            if (out_valid && !out_stall)
            begin
                if (result_elems_due.size() == 0)
                    report_mismatch($sformatf("unexpected result r%0d c%0d v=%08h last=%0b",
                                              row_res, col_res, value_res, last));
                else
                begin
                    exp_e = result_elems_due.pop_front();
                    if (row_res !== exp_e.rix || col_res !== exp_e.cix ||
                        value_res !== exp_e.val || last !== exp_e.fin)
                        report_mismatch($sformatf(
                            "got r%0d c%0d v=%08h last=%0b, want r%0d c%0d v=%08h last=%0b",
                            row_res, col_res, value_res, last,
                            exp_e.rix, exp_e.cix, exp_e.val, exp_e.fin));
                end
            end
            if (in_valid && !in_stall)
                predict_engine(mode_t'(mode), row, col, value);
            pending = result_elems_due.size();
        end
    end

endmodule

`default_nettype wire

// ----- verif/matrix4_arithmetic_engine_top_test.sv -----
// Stimulus and verdict for matrix4_arithmetic_engine_top.
// Depends on m4ae_pkg, the block itself and matrix4_arithmetic_engine_checker.
`default_nettype none

module matrix4_arithmetic_engine_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import m4ae_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    // Non-ignored items in the random part (mode 7 items do not count).
    localparam int RAND_ITEMS = 80;
    localparam int MAX_GAP = 12;
    // Cycles to watch for stray results once nothing is outstanding.
    localparam int DRAIN_CYCLES = 300;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [2:0]               mode;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
    logic                     out_valid;
    logic                     out_stall;
    logic [IDX_W-1:0]         row_res;
    logic [IDX_W-1:0]         col_res;
    logic signed [ELEM_W-1:0] value_res;
    logic                     last;
    int                       errors;
    int                       pending;

    // When set, both sides stop idling, so back-to-back transfers occur too.
    logic                     quiet;

    // Seed contents for the opening loads: extremes, unity, fractions and ordinary values.
    logic signed [ELEM_W-1:0] seed_a [16] = '{
        32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'hFFFFFFFF,
        32'h00010000, 32'hFFFF0000, 32'h00000001, 32'h00008000,
        32'h00020000, 32'hFFFE8000, 32'h00030000, 32'h7FFF0000,
        32'h00004000, 32'hFFFFC000, 32'h12345678, 32'hEDCBA988
    };
    logic signed [ELEM_W-1:0] seed_b [16] = '{
        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
        32'h80000000, 32'h00000001, 32'hFFFFFFFF, 32'h00000000,
        32'hFFFF8000, 32'h00018000, 32'h80000001, 32'h00000002,
        32'h0000C000, 32'hFFFD0000, 32'h5A5AA5A5, 32'hA5A55A5A
    };

    matrix4_arithmetic_engine_top #(
        .FRAC_BITS (FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_res   (row_res),
        .col_res   (col_res),
        .value_res (value_res),
        .last      (last)
    );

    matrix4_arithmetic_engine_checker #(
        .FRAC_BITS (FRAC)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_res   (row_res),
        .col_res   (col_res),
        .value_res (value_res),
        .last      (last),
        .errors    (errors),
        .pending   (pending)
    );

    // 10 ns clock.
    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop: the slowest legal run (every item a multiply, every element stalled
    // for the longest hold, every item preceded by the longest gap) is well under 1 ms.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Switch at random between idling and no-idling stretches of random length.
    initial
    begin
        quiet = 1'b0;
        forever
        begin
            repeat ($urandom_range(100, 600)) @(posedge clk);
            quiet = ($urandom_range(0, 3) == 0);
        end
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Mix of element values: small fixed-point numbers keep products in range,
    // full-width randoms drive saturation, and extremes hit the corners.
    function automatic logic signed [ELEM_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        if (sel < 6)
        begin
            case ($urandom_range(0, 5))
                0: return 32'sh7FFFFFFF;
                1: return 32'sh80000000;
                2: return 32'sh00000000;
                3: return 32'shFFFFFFFF;
                4: return 32'sh00010000;
                default: return 32'sh00000001;
            endcase
        end
        return $urandom();
    endfunction

    // Present one item after a random gap and hold it until the transfer.
    // Called at a falling edge; returns at the falling edge after the transfer with
    // valid still high, so a zero-gap successor never lowers and raises it in one step.
    task automatic send_item(input mode_t op, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c,
                             input logic signed [ELEM_W-1:0] v);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        row      <= r;
        col      <= c;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Result side: stall a random number of cycles per element, then accept it.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = draw_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Reset, directed opening, random body, drain and verdict.
    initial
    begin
        int    counted;
        int    pick;
        mode_t op;

        in_valid = 1'b0;
        mode     = MODE_NOP;
        row      = '0;
        col      = '0;
        value    = '0;
        rst_n    = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill every element of both matrices first: the memories power up unknown
        // and no operation may read an element that was never written.
        for (int i = 0; i < 16; i++)
            send_item(MODE_LOAD_A, i[3:2], i[1:0], seed_a[i]);
        for (int i = 15; i >= 0; i--)
            send_item(MODE_LOAD_B, i[3:2], i[1:0], seed_b[i]);

        // Each operation once, with row/col/value junk where they are ignored;
        // scale by the extremes, minus one and unity; then the unused mode and a scale by zero.
        send_item(MODE_TRANSPOSE, 2'd3, 2'd1, 32'sh7FFFFFFF);
        send_item(MODE_ADD, 2'd0, 2'd3, 32'sh80000000);
        send_item(MODE_SUB, 2'd2, 2'd2, $urandom());
        send_item(MODE_MUL, 2'd1, 2'd0, $urandom());
        send_item(MODE_SCALE, 2'd3, 2'd3, 32'sh7FFFFFFF);
        send_item(MODE_SCALE, 2'd0, 2'd0, 32'sh80000000);
        send_item(MODE_SCALE, 2'd1, 2'd2, 32'shFFFFFFFF);
        send_item(MODE_SCALE, 2'd2, 2'd1, 32'sh00010000);
        send_item(MODE_NOP, 2'd3, 2'd3, 32'shFFFFFFFF);
        send_item(MODE_SCALE, 2'd0, 2'd1, 32'sh00000000);

        // Random body: reloads interleaved with somewhat more operations on the live matrices,
        // plus a sprinkle of the unused mode as noise.
        counted = 0;
        while (counted < RAND_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                send_item(MODE_NOP, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          $urandom());
            else
            begin
                if (pick < 45)
                    op = ($urandom_range(0, 1) != 0) ? MODE_LOAD_B : MODE_LOAD_A;
                else
                    op = mode_t'($urandom_range(MODE_MUL, MODE_TRANSPOSE));
                send_item(op, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          pick_value());
                counted++;
            end
        end
        in_valid <= 1'b0;

        // Wait for every expected element, then watch for strays.
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/m4ae_pkg.sv
sv/matrix4_arithmetic_engine_top.sv
verif/matrix4_arithmetic_engine_checker.sv
verif/matrix4_arithmetic_engine_top_test.sv
